/* rtl/kfce_pkg.sv */
`timescale 1ns / 1ps
// kfce_pkg: shared types and constants for the key frequency table
// no dependencies
package kfce_pkg;
  localparam int KeyW = 32;
  localparam int CntW = 31;
  localparam int SlotW = 7;
  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

  typedef struct packed {
    logic            rej;
    logic [KeyW-1:0] key;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LK_RD,
    ST_LK_CMP,
    ST_SW_RD,
    ST_SW_CMP
  } bk_state_t;
endpackage

/* rtl/kfce_front.sv */
`timescale 1ns / 1ps
// kfce_front: takes requests, flags key zero, holds them in a two-deep queue
// depends on kfce_pkg
module kfce_front import kfce_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [KeyW-1:0] in_key,
  input  logic            bk_init,
  input  logic            pop,
  output logic            q_empty,
  output q_item_t         q_head
);
  q_item_t    q_mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign busy    = (cnt_r == 2'd2) || bk_init;
  assign push    = start && !busy;
  assign q_empty = (cnt_r == 2'd0);
  assign q_head  = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r].rej <= (in_key == '0);
      q_mem_r[wp_r].key <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end
endmodule

/* rtl/kfce_back.sv */
`timescale 1ns / 1ps
// kfce_back: table memories, clearing pass after reset, slot scan for lookup and clock sweep on a miss
// depends on kfce_pkg
module kfce_back import kfce_pkg::*; #(
  parameter int ENTRIES = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  q_item_t          q_head,
  output logic             pop,
  output logic             bk_init,
  output logic             out_valid,
  output logic             out_rejected,
  output logic             out_hit,
  output logic [SlotW-1:0] out_slot,
  output logic [CntW-1:0]  out_count,
  output logic             out_evicted_valid,
  output logic [KeyW-1:0]  out_evicted_key
);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] Last = AW'(ENTRIES - 1);

  logic [KeyW-1:0] keys_m  [ENTRIES];
  logic [CntW-1:0] cnts_m  [ENTRIES];
  logic            marks_m [ENTRIES];

  bk_state_t       state_r, state_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   hand_r, hand_nxt, hand_adv;
  logic [KeyW-1:0] cur_key_r, cur_key_nxt;
  logic [KeyW-1:0] rd_key_r;
  logic [CntW-1:0] rd_cnt_r;
  logic            rd_mark_r;

  logic [AW-1:0]   ra, wa;
  logic            we_key, we_cnt, we_mark;
  logic [KeyW-1:0] wd_key;
  logic [CntW-1:0] wd_cnt;
  logic            wd_mark;

  logic            ov_r, ov_nxt;
  logic            orej_r, orej_nxt, ohit_r, ohit_nxt, oev_r, oev_nxt;
  logic [SlotW-1:0] oslot_r, oslot_nxt;
  logic [CntW-1:0] ocnt_r, ocnt_nxt;
  logic [KeyW-1:0] oek_r, oek_nxt;

  assign hand_adv = (hand_r == Last) ? '0 : hand_r + AW'(1);
  assign bk_init  = (state_r == ST_INIT);

  // table memories
  always_ff @(posedge clk) begin
    if (we_key)  keys_m[wa]  <= wd_key;
    if (we_cnt)  cnts_m[wa]  <= wd_cnt;
    if (we_mark) marks_m[wa] <= wd_mark;
    rd_key_r  <= keys_m[ra];
    rd_cnt_r  <= cnts_m[ra];
    rd_mark_r <= marks_m[ra];
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    hand_nxt    = hand_r;
    cur_key_nxt = cur_key_r;
    pop         = 1'b0;
    ra          = idx_r;
    wa          = idx_r;
    we_key      = 1'b0;
    we_cnt      = 1'b0;
    we_mark     = 1'b0;
    wd_key      = cur_key_r;
    wd_cnt      = CntW'(1);
    wd_mark     = 1'b0;
    ov_nxt      = 1'b0;
    orej_nxt    = 1'b0;
    ohit_nxt    = 1'b0;
    oslot_nxt   = '0;
    ocnt_nxt    = '0;
    oev_nxt     = 1'b0;
    oek_nxt     = '0;
    case (state_r)
      ST_INIT: begin
        we_key  = 1'b1;
        we_mark = 1'b1;
        wd_key  = '0;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == Last) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_head.rej) begin
            ov_nxt   = 1'b1;
            orej_nxt = 1'b1;
          end else begin
            cur_key_nxt = q_head.key;
            idx_nxt     = '0;
            state_nxt   = ST_LK_RD;
          end
        end
      end
      ST_LK_RD: begin
        ra        = idx_r;
        state_nxt = ST_LK_CMP;
      end
      ST_LK_CMP: begin
        if (rd_key_r == cur_key_r) begin
          wa        = idx_r;
          we_cnt    = 1'b1;
          we_mark   = 1'b1;
          wd_cnt    = (rd_cnt_r == CountMax) ? rd_cnt_r : rd_cnt_r + CntW'(1);
          ov_nxt    = 1'b1;
          ohit_nxt  = 1'b1;
          oslot_nxt = SlotW'(idx_r);
          ocnt_nxt  = wd_cnt;
          state_nxt = ST_IDLE;
        end else if (idx_r == Last) begin
          state_nxt = ST_SW_RD;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_LK_RD;
        end
      end
      ST_SW_RD: begin
        hand_nxt  = hand_adv;
        ra        = hand_adv;
        state_nxt = ST_SW_CMP;
      end
      ST_SW_CMP: begin
        wa      = hand_r;
        we_mark = 1'b1;
        if (rd_key_r == '0 || rd_mark_r) begin
          we_key    = 1'b1;
          we_cnt    = 1'b1;
          wd_mark   = 1'b0;
          ov_nxt    = 1'b1;
          oslot_nxt = SlotW'(hand_r);
          ocnt_nxt  = CntW'(1);
          oev_nxt   = (rd_key_r != '0);
          oek_nxt   = rd_key_r;
          state_nxt = ST_IDLE;
        end else begin
          wd_mark   = 1'b1;
          state_nxt = ST_SW_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      idx_r   <= '0;
      hand_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      hand_r  <= hand_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_key_r <= cur_key_nxt;
    orej_r    <= orej_nxt;
    ohit_r    <= ohit_nxt;
    oslot_r   <= oslot_nxt;
    ocnt_r    <= ocnt_nxt;
    oev_r     <= oev_nxt;
    oek_r     <= oek_nxt;
  end

  assign out_valid         = ov_r;
  assign out_rejected      = orej_r;
  assign out_hit           = ohit_r;
  assign out_slot          = oslot_r;
  assign out_count         = ocnt_r;
  assign out_evicted_valid = oev_r;
  assign out_evicted_key   = oek_r;
endmodule

/* rtl/key_frequency_table_clock_evict_unit.sv */
`timescale 1ns / 1ps
// key frequency table with clock replacement, top level
// lookup scans the slots one at a time through the key memory port, a read state
// then a compare state for each; a miss then advances the hand, at most ENTRIES+1 times
// a key of zero is flagged and returned without a scan; the receiver cannot stall results
// after reset a clearing pass over all ENTRIES slots holds busy high
// depends on kfce_pkg, kfce_front, kfce_back
module key_frequency_table_clock_evict_unit import kfce_pkg::*; #(
  parameter int ENTRIES = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [KeyW-1:0]  in_key,
  output logic             out_valid,
  output logic             out_rejected,
  output logic             out_hit,
  output logic [SlotW-1:0] out_slot,
  output logic [CntW-1:0]  out_count,
  output logic             out_evicted_valid,
  output logic [KeyW-1:0]  out_evicted_key
);
  logic    bk_init, pop, q_empty;
  q_item_t q_head;

  kfce_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_key  (in_key),
    .bk_init (bk_init),
    .pop     (pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  kfce_back #(.ENTRIES(ENTRIES)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .pop               (pop),
    .bk_init           (bk_init),
    .out_valid         (out_valid),
    .out_rejected      (out_rejected),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_count         (out_count),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_key   (out_evicted_key)
  );
endmodule

/* dv/tb_key_frequency_table_clock_evict_unit.sv */
`timescale 1ns / 1ps
// testbench for key_frequency_table_clock_evict_unit: random and directed key requests,
// a table model with clock sweep predicts each result, a monitor checks them in order
// depends on kfce_pkg and the key_frequency_table_clock_evict_unit rtl
module tb_key_frequency_table_clock_evict_unit;
  import kfce_pkg::*;

  localparam int NumSlots = 128;
  localparam int DrainCycles = 1200;
  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic             rejected;
    logic             hit;
    logic [SlotW-1:0] slot;
    logic [CntW-1:0]  count;
    logic             evicted_valid;
    logic [KeyW-1:0]  evicted_key;
  } key_result_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [KeyW-1:0]  in_key;
  logic             out_valid;
  logic             out_rejected;
  logic             out_hit;
  logic [SlotW-1:0] out_slot;
  logic [CntW-1:0]  out_count;
  logic             out_evicted_valid;
  logic [KeyW-1:0]  out_evicted_key;

  key_frequency_table_clock_evict_unit #(.ENTRIES(NumSlots)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_rejected(out_rejected),
    .out_hit(out_hit),
    .out_slot(out_slot),
    .out_count(out_count),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_key(out_evicted_key)
  );

  logic [KeyW-1:0] pending_keys[$];
  key_result_t     expected_results[$];
  int              error_count = 0;
  int              cycle_count = 0;

  // table model
  logic [KeyW-1:0] tbl_key[NumSlots];
  logic [CntW-1:0] tbl_count[NumSlots];
  logic            tbl_marked[NumSlots];
  int              tbl_hand;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic key_result_t count_key(logic [KeyW-1:0] key);
    key_result_t r;
    int          s;
    r = '0;
    if (key == '0) begin
      r.rejected = 1'b1;
      return r;
    end
    for (int i = 0; i < NumSlots; i++) begin
      if (tbl_key[i] == key) begin
        tbl_marked[i] = 1'b0;
        if (tbl_count[i] != CountMax) tbl_count[i]++;
        r.hit = 1'b1;
        r.slot = SlotW'(i);
        r.count = tbl_count[i];
        return r;
      end
    end
    s = tbl_hand;
    for (int g = 0; g < 2 * NumSlots + 2; g++) begin
      tbl_hand = (tbl_hand + 1) % NumSlots;
      s = tbl_hand;
      if (tbl_key[s] == '0) break;
      if (tbl_marked[s]) break;
      tbl_marked[s] = 1'b1;
    end
    if (tbl_key[s] != '0) begin
      r.evicted_valid = 1'b1;
      r.evicted_key = tbl_key[s];
    end
    tbl_key[s] = key;
    tbl_count[s] = 1;
    tbl_marked[s] = 1'b0;
    r.slot = SlotW'(s);
    r.count = 1;
    return r;
  endfunction

  // driver: bursts with random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_key <= '0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (start && !busy) expected_results.push_back(count_key(in_key));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_keys.size() > 0) begin
          in_key <= pending_keys.pop_front();
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [KeyW-1:0] exp_v,
                                      logic [KeyW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    key_result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected request result, expected none actual slot %h key %h",
                 $time, out_slot, out_evicted_key);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("rejected", KeyW'(e.rejected), KeyW'(out_rejected));
        check_field("hit", KeyW'(e.hit), KeyW'(out_hit));
        check_field("slot", KeyW'(e.slot), KeyW'(out_slot));
        check_field("count", KeyW'(e.count), KeyW'(out_count));
        check_field("evicted_valid", KeyW'(e.evicted_valid), KeyW'(out_evicted_valid));
        check_field("evicted_key", e.evicted_key, out_evicted_key);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("key_frequency_table_clock_evict_unit verification failed");
      $finish;
    end
  end

  initial begin
    logic [KeyW-1:0] key_pool[$];
    int              pick;
    for (int i = 0; i < NumSlots; i++) begin
      tbl_key[i] = '0;
      tbl_count[i] = '0;
      tbl_marked[i] = 1'b0;
    end
    tbl_hand = 0;

    // directed: zero key, extremes, hits, repeated hits
    pending_keys = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h8000_0000,
                     32'h0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF, 32'h1, 32'h0, 32'hAAAA_AAAA, 32'h0000_0002};

    // pool bigger than the table so the sweep marks and evicts
    for (int i = 0; i < 170; i++) key_pool.push_back($urandom_range(1, 32'hFFFF_FFFF));
    for (int n = 0; n < 550; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        pending_keys.push_back('0);
      end else if (pick < 15) begin
        pending_keys.push_back($urandom);
      end else if (pick < 40) begin
        pending_keys.push_back(key_pool[$urandom_range(0, 31)]);
      end else begin
        pending_keys.push_back(key_pool[$urandom_range(0, key_pool.size() - 1)]);
      end
    end

    @(posedge clk);
    while (rst_n !== 1'b1 || pending_keys.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("key_frequency_table_clock_evict_unit verification clean");
    end else begin
      $display("key_frequency_table_clock_evict_unit verification failed");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/kfce_pkg.sv
rtl/kfce_front.sv
rtl/kfce_back.sv
rtl/key_frequency_table_clock_evict_unit.sv
dv/tb_key_frequency_table_clock_evict_unit.sv
